[src/lzsd_pkg.sv]
// Package for the LZSS stream decompressor: window constants, state codes
// and the structs passed between the control and history modules.
// No dependencies.
package lzsd_pkg;

   localparam int WINDOW_SIZE   = 4096;
   localparam int ADDR_W        = $clog2(WINDOW_SIZE);
   localparam int COUNT_W_DEF   = 24;
   localparam int LIMIT_W       = 24;
   localparam int MATCH_MIN     = 3;
   localparam int MATCH_MAX     = 18;
   localparam int RUN_W         = $clog2(MATCH_MAX + 1);
   localparam logic [ADDR_W-1:0] START_POS = ADDR_W'(WINDOW_SIZE - MATCH_MAX);
   localparam logic [7:0]        FILL_BYTE = 8'h20;

   typedef enum logic [2:0] {
      PH_FLAG = 3'b001,
      PH_ITEM = 3'b010,
      PH_POS2 = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_COPY = 2'b10
   } eng_state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } mem_req_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       run_last;
      logic       stream_done;
   } emit_type;

endpackage

[src/lzsd_history.sv]
// History window: 4096 x 8 synchronous memory with a fill count standing in
// for the space-filled reset image, plus same-cycle write forwarding.
// Depends on lzsd_pkg.
module lzsd_history
   import lzsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_byte
);

   logic [7:0]        mem [WINDOW_SIZE];
   logic [ADDR_W:0]   fill_ff;
   logic [ADDR_W:0]   fill_in;
   logic [7:0]        q_ff;
   logic              rdv_ff;
   logic              fwd_ff;
   logic [7:0]        fwd_data_ff;
   logic [ADDR_W-1:0] rd_ofs;
   logic              rd_written;

   assign rd_ofs     = mem_req.rd_addr - START_POS;
   assign rd_written = {1'b0, rd_ofs} < fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (mem_req.wr_en && fill_ff != (ADDR_W+1)'(WINDOW_SIZE)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         q_ff        <= mem[mem_req.rd_addr];
         rdv_ff      <= rd_written;
         fwd_ff      <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
         fwd_data_ff <= mem_req.wr_data;
      end
   end

   assign rd_byte = fwd_ff ? fwd_data_ff : (rdv_ff ? q_ff : FILL_BYTE);

endmodule

[src/lzsd_ctrl.sv]
// Stream parser and copy engine: flag/literal/pair decode, match copy
// sequencing through the history memory, byte count and limit register.
// Depends on lzsd_pkg.
module lzsd_ctrl
   import lzsd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_W_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   input  logic [7:0]         req_in_byte,
   output logic               req_stall,
   input  logic               out_free,
   output emit_type           emit,
   output mem_req_type        mem_req,
   input  logic [7:0]         rd_byte
);

   localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

   logic [LIMIT_W-1:0]     out_length_ff;
   logic [ADDR_W-1:0]      write_pos_ff, write_pos_in;
   logic [7:0]             flag_bits_ff, flag_bits_in;
   logic [3:0]             flags_left_ff, flags_left_in;
   phase_type              phase_ff, phase_in;
   logic [7:0]             pos_low_ff, pos_low_in;
   logic [COUNT_WIDTH-1:0] produced_ff, produced_in, produced_nx;
   logic                   finished_ff, finished_in;
   eng_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]      rd_addr_ff, rd_addr_in;
   logic [RUN_W-1:0]       cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;

   logic       accept;
   logic       stop;
   logic       lit_emit;
   logic       copy_emit;
   logic       emit_v;
   logic [7:0] emit_byte;
   logic       done;
   logic       rd_en;
   logic [3:0] left_dec;

   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign stop      = finished_ff ||
                      (CMP_W'(produced_ff) >= CMP_W'(out_length_ff));
   assign lit_emit  = accept && !stop && (phase_ff == PH_ITEM) && flag_bits_ff[0];
   assign copy_emit = (state_ff == ST_COPY) && pend_ff && out_free;
   assign emit_v    = lit_emit || copy_emit;
   assign emit_byte = lit_emit ? req_in_byte : rd_byte;

   assign produced_nx = (produced_ff == '1) ? produced_ff : produced_ff + 1'b1;
   assign done        = CMP_W'(produced_nx) >= CMP_W'(out_length_ff);

   assign emit.valid       = emit_v;
   assign emit.data        = emit_byte;
   assign emit.run_last    = lit_emit || (cnt_ff == '0) || done;
   assign emit.stream_done = done;

   assign rd_en = (state_ff == ST_COPY) && (cnt_ff != '0) &&
                  (!pend_ff || copy_emit) && !(copy_emit && done);

   assign mem_req.rd_en   = rd_en;
   assign mem_req.rd_addr = rd_addr_ff;
   assign mem_req.wr_en   = emit_v;
   assign mem_req.wr_addr = write_pos_ff;
   assign mem_req.wr_data = emit_byte;

   assign left_dec = (flags_left_ff != 4'd0) ? flags_left_ff - 4'd1 : 4'd0;

   always_comb begin
      write_pos_in  = write_pos_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      phase_in      = phase_ff;
      pos_low_in    = pos_low_ff;
      produced_in   = produced_ff;
      finished_in   = finished_ff;
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;

      if (emit_v) begin
         write_pos_in = write_pos_ff + 1'b1;
         produced_in  = produced_nx;
         if (done) begin
            finished_in = 1'b1;
         end
      end

      if (accept) begin
         if (stop) begin
            finished_in = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_ITEM: begin
                  if (flag_bits_ff[0]) begin
                     flag_bits_in  = {1'b0, flag_bits_ff[7:1]};
                     flags_left_in = left_dec;
                     phase_in      = (left_dec != 4'd0) ? PH_ITEM : PH_FLAG;
                  end else begin
                     pos_low_in = req_in_byte;
                     phase_in   = PH_POS2;
                  end
               end
               PH_POS2: begin
                  flag_bits_in  = {1'b0, flag_bits_ff[7:1]};
                  flags_left_in = left_dec;
                  phase_in      = (left_dec != 4'd0) ? PH_ITEM : PH_FLAG;
                  rd_addr_in    = {req_in_byte[7:4], pos_low_ff};
                  cnt_in        = RUN_W'(req_in_byte[3:0]) + RUN_W'(MATCH_MIN);
                  pend_in       = 1'b0;
                  state_in      = ST_COPY;
               end
               default: begin
                  flag_bits_in  = req_in_byte;
                  flags_left_in = 4'd8;
                  phase_in      = PH_ITEM;
               end
            endcase
         end
      end

      if (state_ff == ST_COPY) begin
         if (rd_en) begin
            rd_addr_in = rd_addr_ff + 1'b1;
            cnt_in     = cnt_ff - 1'b1;
            pend_in    = 1'b1;
         end else if (copy_emit) begin
            pend_in = 1'b0;
         end
         if (copy_emit && done) begin
            cnt_in  = '0;
            pend_in = 1'b0;
         end
         if (cnt_in == '0 && !pend_in) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_length_ff <= '0;
         write_pos_ff  <= START_POS;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         phase_ff      <= PH_FLAG;
         pos_low_ff    <= '0;
         produced_ff   <= '0;
         finished_ff   <= 1'b0;
         state_ff      <= ST_IDLE;
         rd_addr_ff    <= '0;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            out_length_ff <= csr_wr_data;
         end
         write_pos_ff  <= write_pos_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         phase_ff      <= phase_in;
         pos_low_ff    <= pos_low_in;
         produced_ff   <= produced_in;
         finished_ff   <= finished_in;
         state_ff      <= state_in;
         rd_addr_ff    <= rd_addr_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
      end
   end

endmodule

[src/lzss_stream_decompressor.sv]
// Top level of the LZSS stream decompressor (4096-byte window, 18-byte match).
// Depends on lzsd_pkg, lzsd_history and lzsd_ctrl.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_in_byte[7:0]
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_run_last, rsp_stream_done
//   csr     | in        | csr_wr_en            | csr_wr_data[23:0] (out_length)
//
// Flag bytes, pair first bytes and literals are taken one per cycle when the
// input is not stalled. A pair second byte starts a copy that emits one byte
// per cycle while the output register can take it, set by the single read
// port of the history memory and its registered read. Input stalls while a
// copy runs or the output register is full. Reset is synchronous; the space-filled
// window needs no clearing pass, a fill count marks the entries written since reset.
module lzss_stream_decompressor
   import lzsd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_W_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_stream_done
);

   mem_req_type mem_req;
   emit_type    emit;
   logic [7:0]  rd_byte;
   logic        out_free;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_done_ff;

   assign out_free = !out_valid_ff || !rsp_stall;

   lzsd_ctrl #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .emit        (emit),
      .mem_req     (mem_req),
      .rd_byte     (rd_byte)
   );

   lzsd_history u_history (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_byte (rd_byte)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit.valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         out_byte_ff <= emit.data;
         out_last_ff <= emit.run_last;
         out_done_ff <= emit.stream_done;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_last    = out_last_ff;
   assign rsp_stream_done = out_done_ff;

endmodule
